>>> rtl/ax25_frame_fcs_builder_core_defines.svh
// Assertion macros shared by the frame builder modules.
// A module that uses them must have signals named clk and rst_n in scope.
`ifndef AX25_FRAME_FCS_BUILDER_CORE_DEFINES_SVH
`define AX25_FRAME_FCS_BUILDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define AX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AX_ASSERT(lbl, prop, msg)
`define AX_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/ax25fb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ax25fb_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 7;
  localparam int CRC_W      = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [POS_W-1:0] POS_MAX         = 7'd127;
  localparam logic [POS_W-1:0] LAST_ADDR_RESET = 7'd20;
  localparam logic [CRC_W-1:0] CRC_INIT        = 16'hFFFF;

  // One queue entry per accepted input byte.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eof;
    logic [CRC_W-1:0]  fcs;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Reflected CRC-16-CCITT update over one byte, LSB first.
  function automatic logic [CRC_W-1:0] fcs_step(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    logic [CRC_W-1:0]  r;
    t = b ^ crc[7:0];
    t = t ^ (t << 4);
    r = {t, crc[15:8]};
    r = r ^ {8'h00, (t >> 4)} ^ ({8'h00, t} << 3);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ax25fb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ax25fb_in_if;
  logic                           valid;
  logic                           ready;
  logic [ax25fb_pkg::BYTE_W-1:0]  data_byte;
  logic                           end_of_frame;

  modport source (output valid, data_byte, end_of_frame, input ready);
  modport sink   (input valid, data_byte, end_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/ax25fb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ax25fb_out_if;
  logic                           valid;
  logic                           ready;
  logic [ax25fb_pkg::BYTE_W-1:0]  out_byte;
  logic                           is_fcs;
  logic                           frame_last;

  modport source (output valid, out_byte, is_fcs, frame_last, input ready);
  modport sink   (input valid, out_byte, is_fcs, frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/ax25_frame_fcs_builder_core.sv
// AX.25 frame builder with X.25 frame check sequence.
// in_ch carries one raw frame byte per transaction plus end_of_frame on the
// last content byte. Bytes up to the configured last address index are
// shifted left by one; the byte at that index gets the address-end mark.
// out_ch carries the bytes as sent; a frame's last content byte is followed
// by the complemented CRC, low byte then high byte, with is_fcs set on both
// and frame_last on the high one. cfg_we/cfg_wdata write the last address
// index, which takes effect from the next byte.
// When the path is empty, a byte accepted on in_ch is written into the queue,
// then loaded into the output register and offered on out_ch from there.
// Throughput is one output byte per cycle while the receiver is ready, so one
// input byte per cycle, except that a frame end adds the two check bytes to
// the output; a four-entry queue lets input continue while those are sent.
// Reset (rst_n low, synchronous) restores the index to 20, the CRC to 0xFFFF
// and the position to zero, and empties the queue and output register.
// When the receiver stalls, the output register holds its transaction, the
// queue fills, and in_ch.ready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module ax25_frame_fcs_builder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ax25fb_pkg::POS_W-1:0]  cfg_wdata,
  ax25fb_in_if.sink                          in_ch,
  ax25fb_out_if.source                       out_ch
);

  ax25fb_pkg::q_push_t q_push;
  ax25fb_pkg::q_head_t q_head;
  logic                q_full;
  logic                q_pop;

  // Front half: byte shaping and CRC.
  ax25fb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // Queue decoupling the two halves.
  ax25fb_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_full (q_full),
    .q_head (q_head)
  );

  // Back half: emits content and check bytes through the output register.
  ax25fb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/ax25fb_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Accepts raw bytes, applies the address shift and end mark, runs the CRC
// and queues each byte with the complemented CRC through that byte.
module ax25fb_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ax25fb_pkg::POS_W-1:0]  cfg_wdata,
  ax25fb_in_if.sink                          in_ch,
  input  wire logic                          q_full,
  output ax25fb_pkg::q_push_t                q_push
);

  logic [ax25fb_pkg::POS_W-1:0]  last_addr_r;
  logic [ax25fb_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [ax25fb_pkg::CRC_W-1:0]  crc_r, crc_nxt;
  logic [ax25fb_pkg::CRC_W-1:0]  crc_upd;
  logic [ax25fb_pkg::BYTE_W-1:0] byte_tx;
  logic                          accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    byte_tx = in_ch.data_byte;
    if (pos_r <= last_addr_r) begin
      byte_tx = {in_ch.data_byte[ax25fb_pkg::BYTE_W-2:0], 1'b0};
      if (pos_r == last_addr_r) begin
        byte_tx[0] = 1'b1;
      end
    end
  end

  assign crc_upd = ax25fb_pkg::fcs_step(crc_r, byte_tx);

  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (in_ch.end_of_frame) begin
        crc_nxt = ax25fb_pkg::CRC_INIT;
        pos_nxt = '0;
      end else begin
        crc_nxt = crc_upd;
        pos_nxt = (pos_r == ax25fb_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
      end
    end
  end

  assign q_push.push      = accept;
  assign q_push.entry.data = byte_tx;
  assign q_push.entry.eof  = in_ch.end_of_frame;
  assign q_push.entry.fcs  = ~crc_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_addr_r <= ax25fb_pkg::LAST_ADDR_RESET;
      pos_r       <= '0;
      crc_r       <= ax25fb_pkg::CRC_INIT;
    end else begin
      if (cfg_we) begin
        last_addr_r <= cfg_wdata;
      end
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ax25fb_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ax25_frame_fcs_builder_core_defines.svh"

// Short queue between the front and back halves.
module ax25fb_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ax25fb_pkg::q_push_t   q_push,
  input  wire logic                  q_pop,
  output logic                       q_full,
  output ax25fb_pkg::q_head_t        q_head
);

  ax25fb_pkg::q_entry_t                mem_r [ax25fb_pkg::FIFO_DEPTH];
  logic [ax25fb_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [ax25fb_pkg::FIFO_CNT_W-1:0]  count_r;
  logic                               do_pop;

  assign q_full       = (count_r == ax25fb_pkg::FIFO_CNT_W'(ax25fb_pkg::FIFO_DEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.entry = mem_r[rd_ptr_r];
  assign do_pop       = q_pop && q_head.valid;

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (q_push.push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!q_push.push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `AX_ASSERT(a_count_bound, (count_r <= ax25fb_pkg::FIFO_CNT_W'(ax25fb_pkg::FIFO_DEPTH)), "fifo count exceeds depth")
  `AX_ASSERT(a_no_overflow, !(q_push.push && q_full && !q_pop), "push into full fifo")
  `AX_ASSERT(a_pop_moves_count, (do_pop && !q_push.push) |=> (count_r == $past(count_r) - 1'b1), "pop did not drain an entry")

endmodule

`default_nettype wire

>>> rtl/ax25fb_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ax25_frame_fcs_builder_core_defines.svh"

// Expands each queued byte into one or three output bytes and holds them
// in an output register.
module ax25fb_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ax25fb_pkg::q_head_t   q_head,
  output logic                       q_pop,
  ax25fb_out_if.source               out_ch
);

  typedef enum logic [2:0] {
    PH_DATA   = 3'b001,
    PH_FCS_LO = 3'b010,
    PH_FCS_HI = 3'b100
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic                          out_valid_r;
  logic [ax25fb_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                          is_fcs_r, is_fcs_nxt;
  logic                          frame_last_r, frame_last_nxt;
  logic                          load;
  logic                          emit;

  assign load = !out_valid_r || out_ch.ready;
  assign emit = load && q_head.valid;

  always_comb begin
    phase_nxt      = phase_r;
    q_pop          = 1'b0;
    out_byte_nxt   = q_head.entry.data;
    is_fcs_nxt     = 1'b0;
    frame_last_nxt = 1'b0;
    unique case (phase_r)
      PH_DATA: begin
        if (emit) begin
          if (q_head.entry.eof) begin
            phase_nxt = PH_FCS_LO;
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      PH_FCS_LO: begin
        out_byte_nxt = q_head.entry.fcs[7:0];
        is_fcs_nxt   = 1'b1;
        if (emit) begin
          phase_nxt = PH_FCS_HI;
        end
      end
      PH_FCS_HI: begin
        out_byte_nxt   = q_head.entry.fcs[15:8];
        is_fcs_nxt     = 1'b1;
        frame_last_nxt = 1'b1;
        if (emit) begin
          phase_nxt = PH_DATA;
          q_pop     = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= q_head.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r   <= out_byte_nxt;
      is_fcs_r     <= is_fcs_nxt;
      frame_last_r <= frame_last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.is_fcs     = is_fcs_r;
  assign out_ch.frame_last = frame_last_r;

  `AX_ASSERT(a_fcs_needs_head, (phase_r != PH_DATA) |-> q_head.valid, "check bytes pending without queued entry")
  `AX_ASSERT(a_last_is_fcs, (out_valid_r && frame_last_r) |-> is_fcs_r, "frame end on a non-check byte")
  `AX_ASSERT(a_hi_follows_lo, (out_valid_r && out_ch.ready && is_fcs_r && !frame_last_r) |=> (out_valid_r && frame_last_r), "high check byte did not follow low one")

endmodule

`default_nettype wire
